// File: rtl/swpd_pkg.sv
package swpd_pkg;

  localparam int unsigned LENGTH_BITS_DEF = 32;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;
  localparam logic [31:0] SYNC_RESET      = 32'h5244_4950;
  localparam logic [7:0]  MAX_KNOWN_ID    = 8'd4;

  localparam logic KIND_PAYLOAD   = 1'b0;
  localparam logic KIND_SYNC_LOST = 1'b1;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] payload_byte;
    logic       is_id_byte;
    logic       is_last;
    logic       unknown_id;
  } rslt_t;

endpackage

// File: rtl/swpd_front.sv
module swpd_front #(
  parameter int unsigned LENGTH_BITS = swpd_pkg::LENGTH_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic [7:0]        in_data_byte,
  input  logic              cfg_fire,
  input  logic [31:0]       cfg_sync_word,
  output logic              push,
  output swpd_pkg::rslt_t   push_rslt
);

  localparam logic [LENGTH_BITS-1:0] LEN_ONE = LENGTH_BITS'(1);

  swpd_pkg::phase_t       phase_r, phase_nxt;
  logic [31:0]            sync_r;
  logic [31:0]            window_r, window_nxt;
  logic [2:0]             fill_r, fill_nxt;
  logic [1:0]             lbs_r, lbs_nxt;
  logic [31:0]            acc_r, acc_nxt;
  logic [LENGTH_BITS-1:0] remain_r, remain_nxt;
  logic                   mism_r, mism_nxt;
  logic                   expect_id_r, expect_id_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= swpd_pkg::PH_HUNT;
      sync_r      <= swpd_pkg::SYNC_RESET;
      window_r    <= '0;
      fill_r      <= '0;
      lbs_r       <= '0;
      acc_r       <= '0;
      remain_r    <= '0;
      mism_r      <= 1'b0;
      expect_id_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      window_r    <= window_nxt;
      fill_r      <= fill_nxt;
      lbs_r       <= lbs_nxt;
      acc_r       <= acc_nxt;
      remain_r    <= remain_nxt;
      mism_r      <= mism_nxt;
      expect_id_r <= expect_id_nxt;
      if (cfg_fire) begin
        sync_r <= cfg_sync_word;
      end
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    window_nxt    = window_r;
    fill_nxt      = fill_r;
    lbs_nxt       = lbs_r;
    acc_nxt       = acc_r;
    remain_nxt    = remain_r;
    mism_nxt      = mism_r;
    expect_id_nxt = expect_id_r;
    push          = 1'b0;
    push_rslt     = '0;
    if (in_fire) begin
      unique case (phase_r)
        swpd_pkg::PH_LEN: begin
          // length arrives little-endian, one byte per transaction
          acc_nxt = acc_r | (32'(in_data_byte) << {lbs_r, 3'b000});
          lbs_nxt = lbs_r + 2'd1;
          if (lbs_r == 2'd3) begin
            if (acc_nxt == 32'd0) begin
              // empty packet is dropped
              phase_nxt     = swpd_pkg::PH_HUNT;
              window_nxt    = '0;
              fill_nxt      = '0;
              lbs_nxt       = '0;
              acc_nxt       = '0;
              remain_nxt    = '0;
              expect_id_nxt = 1'b0;
            end else begin
              // saturate lengths that do not fit the counter
              if ((acc_nxt >> LENGTH_BITS) != 32'd0) begin
                remain_nxt = '1;
              end else begin
                remain_nxt = acc_nxt[LENGTH_BITS-1:0];
              end
              phase_nxt     = swpd_pkg::PH_DATA;
              expect_id_nxt = 1'b1;
              acc_nxt       = '0;
            end
          end
        end
        swpd_pkg::PH_DATA: begin
          push                   = 1'b1;
          push_rslt.kind         = swpd_pkg::KIND_PAYLOAD;
          push_rslt.payload_byte = in_data_byte;
          push_rslt.is_id_byte   = expect_id_r;
          push_rslt.is_last      = (remain_r <= LEN_ONE);
          push_rslt.unknown_id   = expect_id_r && (in_data_byte > swpd_pkg::MAX_KNOWN_ID);
          expect_id_nxt          = 1'b0;
          remain_nxt             = remain_r - LEN_ONE;
          if (remain_r <= LEN_ONE) begin
            phase_nxt     = swpd_pkg::PH_HUNT;
            window_nxt    = '0;
            fill_nxt      = '0;
            lbs_nxt       = '0;
            acc_nxt       = '0;
            remain_nxt    = '0;
            expect_id_nxt = 1'b0;
          end
        end
        default: begin
          // hunting, also covers the unused phase code
          phase_nxt  = swpd_pkg::PH_HUNT;
          window_nxt = {in_data_byte, window_r[31:8]};
          if (fill_r < 3'd4) begin
            fill_nxt = fill_r + 3'd1;
          end
          if (fill_nxt == 3'd4) begin
            if (window_nxt == sync_r) begin
              mism_nxt   = 1'b0;
              phase_nxt  = swpd_pkg::PH_LEN;
              lbs_nxt    = '0;
              acc_nxt    = '0;
              remain_nxt = '0;
              window_nxt = '0;
              fill_nxt   = '0;
            end else if (!mism_r) begin
              mism_nxt       = 1'b1;
              push           = 1'b1;
              push_rslt.kind = swpd_pkg::KIND_SYNC_LOST;
            end
          end
        end
      endcase
    end
  end

endmodule

// File: rtl/swpd_queue.sv
module swpd_queue #(
  parameter int unsigned DEPTH = swpd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  swpd_pkg::rslt_t push_rslt,
  output logic            full,
  output logic            out_valid,
  input  logic            out_stall,
  output swpd_pkg::rslt_t head
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  swpd_pkg::rslt_t slot_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]     count_r, count_nxt;
  logic            pop;

  assign full      = (count_r == (AW+1)'(DEPTH));
  assign out_valid = (count_r != '0);
  assign pop       = out_valid && !out_stall;
  assign head      = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + (AW+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_rslt;
    end
  end

endmodule

// File: rtl/sync_word_packet_deframer.sv
// channel   direction  handshake           payload
// in_       input      in_valid/in_stall    in_data_byte[7:0]
// out_      output     out_valid/out_stall  out_kind, out_payload_byte[7:0], out_is_id_byte,
//                                           out_is_last, out_unknown_id
// cfg_      input      cfg_valid/cfg_ready  cfg_sync_word[31:0]
//
// one byte per cycle while in_stall is low: the front classifies and updates
// its state in the accepting cycle, a result is registered and appears on out_ from the queue
// rst_n is synchronous; after reset the block hunts with sync word 0x52444950
// in_stall rises only when the QUEUE_DEPTH-entry result queue is full
// cfg_ready is always high
module sync_word_packet_deframer #(
  parameter int unsigned LENGTH_BITS = swpd_pkg::LENGTH_BITS_DEF,
  parameter int unsigned QUEUE_DEPTH = swpd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  out_payload_byte,
  output logic        out_is_id_byte,
  output logic        out_is_last,
  output logic        out_unknown_id,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_sync_word
);

  logic            full;
  logic            in_fire;
  logic            push;
  swpd_pkg::rslt_t push_rslt;
  swpd_pkg::rslt_t head;

  assign in_stall  = full;
  assign in_fire   = in_valid && !full;
  assign cfg_ready = 1'b1;

  swpd_front #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_fire       (in_fire),
    .in_data_byte  (in_data_byte),
    .cfg_fire      (cfg_valid),
    .cfg_sync_word (cfg_sync_word),
    .push          (push),
    .push_rslt     (push_rslt)
  );

  swpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_rslt (push_rslt),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign out_kind         = head.kind;
  assign out_payload_byte = head.payload_byte;
  assign out_is_id_byte   = head.is_id_byte;
  assign out_is_last      = head.is_last;
  assign out_unknown_id   = head.unknown_id;

endmodule
